// ----- src/ple_pkg.sv -----
// Shared types and operation codes for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_GET    = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  position;
    logic [31:0] value;
  } ple_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [4:0]  count;
  } ple_rsp_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } ple_ctrl_t;

endpackage

// ----- src/positional_list_engine_core.sv -----
// Top level of the positional list engine: request decode, count and result register.
//
// Fixed-capacity ordered list of words held in a row of cells.
// request channel: operation (append, insert, pop, remove, get), position
// and value, taken when request_valid is high and request_stall is low.
// result channel: ok, read_value (nonzero only for a good get) and the
// count after the request, shown when result_valid is high and taken when
// result_stall is low.
// The result is registered and shows the cycle after the request is taken. A new
// request can be taken in every cycle while request_stall is low; insert and remove
// shift the cells from the position upward one place in that same cycle, so the
// rate is set by the cell row plus the get read mux.
// While a result is held by result_stall, request_stall is raised and the
// held result stays unchanged.
// Reset clears the count and the result valid; entry contents are not
// cleared and are only read after being written.
`timescale 1ns / 1ps

module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int CAPACITY     = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     request_valid,
  output logic     request_stall,
  input  ple_req_t request,
  output logic     result_valid,
  input  logic     result_stall,
  output ple_rsp_t result
);

  localparam int UW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = (UW > 5) ? UW : 5;
  localparam logic [UW-1:0] FULL = UW'(CAPACITY);

  logic [UW-1:0]           used;
  logic [UW-1:0]           used_next;
  logic [ELEMENT_BITS-1:0] row [CAPACITY];
  logic [ELEMENT_BITS-1:0] wr_val;
  logic [UW-1:0]           idx;
  logic [CW-1:0]           pos_x;
  logic [CW-1:0]           used_x;
  logic [AW-1:0]           rd_idx;
  logic                    full;
  logic                    empty;
  logic                    req_fire;
  ple_ctrl_t               ctrl;
  ple_rsp_t                rsp_next;

  assign request_stall = result_valid && result_stall;
  assign req_fire      = request_valid && !request_stall;

  assign full   = (used == FULL);
  assign empty  = (used == '0);
  assign pos_x  = CW'(request.position);
  assign used_x = CW'(used);
  assign rd_idx = AW'(request.position);
  assign wr_val = ELEMENT_BITS'(request.value);
  assign idx    = (request.operation == OP_APPEND) ? used : UW'(request.position);

  always_comb begin
    ctrl      = '0;
    used_next = used;
    rsp_next  = '0;
    unique case (request.operation)
      OP_APPEND: begin
        if (!full) begin
          ctrl.ins    = 1'b1;
          used_next   = used + 1'b1;
          rsp_next.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (!full && pos_x <= used_x) begin
          ctrl.ins    = 1'b1;
          used_next   = used + 1'b1;
          rsp_next.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (!empty) begin
          used_next   = used - 1'b1;
          rsp_next.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_x < used_x) begin
          ctrl.rem    = 1'b1;
          used_next   = used - 1'b1;
          rsp_next.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (pos_x < used_x) begin
          rsp_next.ok         = 1'b1;
          rsp_next.read_value = 32'(row[rd_idx]);
        end
      end
      default: begin
      end
    endcase
    if (!req_fire) begin
      ctrl = '0;
    end
    rsp_next.count = 5'(used_next);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left;
    logic [ELEMENT_BITS-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = row[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = row[i+1];
    end

    ple_cell #(
      .IDX (i),
      .IW  (UW),
      .DW  (ELEMENT_BITS)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (idx),
      .val   (wr_val),
      .left  (left),
      .right (right),
      .q     (row[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      result_valid <= 1'b0;
    end else if (req_fire) begin
      used         <= used_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      result <= rsp_next;
    end
  end

endmodule

// ----- src/ple_cell.sv -----
// One list entry: loads the new word, takes its left or right neighbor, or holds.
`timescale 1ns / 1ps

module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 5,
  parameter int DW  = 32
) (
  input  logic          clk,
  input  ple_ctrl_t     ctrl,
  input  logic [IW-1:0] idx,
  input  logic [DW-1:0] val,
  input  logic [DW-1:0] left,
  input  logic [DW-1:0] right,
  output logic [DW-1:0] q
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic at_idx;
  logic above_idx;

  assign at_idx    = (MY_IDX == idx);
  assign above_idx = (MY_IDX > idx);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (at_idx) begin
        q <= val;
      end else if (above_idx) begin
        q <= left;
      end
    end else if (ctrl.rem) begin
      if (at_idx || above_idx) begin
        q <= right;
      end
    end
  end

endmodule

// ----- src/ple_checker.sv -----
// Port-level checks for the positional list engine, bound to the top level.
`timescale 1ns / 1ps

module ple_checker
  import ple_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     request_valid,
  input logic     request_stall,
  input logic     result_valid,
  input logic     result_stall,
  input ple_rsp_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall |=> result_valid)
    else $error("request did not produce a result next cycle");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    request_stall |-> result_valid && result_stall)
    else $error("request stalled without a held result");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (.*);

// ----- tb/tb_positional_list_engine_core.sv -----
// Self-checking testbench for positional_list_engine_core: list ops with random handshake gaps.
`timescale 1ns / 1ps

module tb_positional_list_engine_core;
  import ple_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_REQS = 1000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  ple_req_t request = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  ple_rsp_t result;

  ple_req_t    pending_reqs[$];
  ple_rsp_t    expected_rsps[$];
  logic [31:0] list_words[LIST_DEPTH];
  int          list_len = 0;
  int          gen_len = 0;
  int          total_reqs = 0;
  int          reqs_taken = 0;
  int          rsps_taken = 0;
  int          mismatches = 0;
  int          req_gap = 0;
  int          rsp_gap = 0;

  positional_list_engine_core dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  always #5 clk = ~clk;

  // Applies one request to the shadow list and returns the expected result.
  function automatic ple_rsp_t list_apply(ple_req_t rq);
    ple_rsp_t rs;
    int i;
    rs = '0;
    case (rq.operation)
      OP_APPEND: if (list_len < LIST_DEPTH) begin
        list_words[list_len] = rq.value;
        list_len++;
        rs.ok = 1'b1;
      end
      OP_INSERT: if (list_len < LIST_DEPTH && rq.position <= list_len) begin
        for (i = list_len; i > rq.position; i--) list_words[i] = list_words[i - 1];
        list_words[rq.position] = rq.value;
        list_len++;
        rs.ok = 1'b1;
      end
      OP_POP: if (list_len > 0) begin
        list_len--;
        rs.ok = 1'b1;
      end
      OP_REMOVE: if (rq.position < list_len) begin
        for (i = rq.position; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
        list_len--;
        rs.ok = 1'b1;
      end
      OP_GET: if (rq.position < list_len) begin
        rs.read_value = list_words[rq.position];
        rs.ok = 1'b1;
      end
      default: ;
    endcase
    rs.count = 5'(list_len);
    return rs;
  endfunction

  // Mostly short gaps, a few long ones, and some stretches with none.
  function automatic int pick_gap(int key);
    int r;
    if ((key / 150) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queues a request and tracks the count it leaves, to aim later positions.
  task automatic add_req(logic [2:0] op, logic [4:0] pos, logic [31:0] val);
    ple_req_t rq;
    rq.operation = op;
    rq.position  = pos;
    rq.value     = val;
    pending_reqs.push_back(rq);
    total_reqs++;
    case (op)
      OP_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
      OP_INSERT: if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
      OP_POP:    if (gen_len > 0) gen_len--;
      OP_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
      req_gap = pick_gap(0);
    end else begin
      if (request_valid && !request_stall) begin
        expected_rsps.push_back(list_apply(request));
        reqs_taken++;
        req_gap = pick_gap(reqs_taken);
      end
      if (!request_valid || !request_stall) begin
        if (req_gap > 0) begin
          req_gap--;
          request_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request       <= pending_reqs.pop_front();
          request_valid <= 1'b1;
        end else begin
          request_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ple_rsp_t want;
    if (rst) begin
      result_stall <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (result_valid && !result_stall) begin
        rsps_taken++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, actual ok=%0b read_value=%h count=%0d",
                   $time, result.ok, result.read_value, result.count);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (result.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, result.ok);
            mismatches++;
          end
          if (result.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, result.read_value);
            mismatches++;
          end
          if (result.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, result.count);
            mismatches++;
          end
        end
      end
      if (rsp_gap == 0) rsp_gap = pick_gap(rsps_taken);
      result_stall <= (rsp_gap > 0);
      if (rsp_gap > 0) rsp_gap--;
    end
  end

  initial begin
    int trend;
    int r;
    logic [2:0] op;
    logic [4:0] pos;

    // empty list
    add_req(OP_POP, 5'd0, rand_word());
    add_req(OP_REMOVE, 5'd0, rand_word());
    add_req(OP_GET, 5'd0, rand_word());
    add_req(OP_GET, 5'd31, rand_word());
    add_req(OP_INSERT, 5'd1, 32'hDEAD_BEEF);
    for (int c = OP_GET + 1; c < 8; c++) add_req(3'(c), 5'($urandom), rand_word());
    // small list, edges of the position range
    add_req(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    add_req(OP_APPEND, 5'd31, 32'h0);
    add_req(OP_INSERT, 5'd2, 32'hA5A5_A5A5);
    add_req(OP_INSERT, 5'd1, 32'h1234_5678);
    add_req(OP_GET, 5'd0, 32'h0);
    add_req(OP_GET, 5'd3, 32'h0);
    add_req(OP_GET, 5'd4, 32'h0);
    add_req(OP_REMOVE, 5'd3, 32'h0);
    add_req(OP_REMOVE, 5'd0, 32'h0);
    add_req(OP_REMOVE, 5'd2, 32'h0);
    // fill to capacity, then hit the full list
    while (gen_len < LIST_DEPTH) begin
      if (gen_len % 2 == 0) add_req(OP_APPEND, 5'd0, $urandom);
      else add_req(OP_INSERT, 5'($urandom_range(0, gen_len)), $urandom);
    end
    add_req(OP_GET, 5'd15, 32'h0);
    add_req(OP_APPEND, 5'd0, 32'h5555_5555);
    add_req(OP_INSERT, 5'd0, 32'h5555_5555);
    add_req(OP_GET, 5'd16, 32'h0);
    add_req(OP_REMOVE, 5'd15, 32'h0);

    trend = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) trend = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (trend)
        0: op = (r < 30) ? OP_APPEND : (r < 65) ? OP_INSERT : (r < 70) ? OP_POP :
                (r < 80) ? OP_REMOVE : (r < 97) ? OP_GET : 3'($urandom_range(5, 7));
        1: op = (r < 5) ? OP_APPEND : (r < 15) ? OP_INSERT : (r < 40) ? OP_POP :
                (r < 75) ? OP_REMOVE : (r < 97) ? OP_GET : 3'($urandom_range(5, 7));
        default: op = (r < 18) ? OP_APPEND : (r < 38) ? OP_INSERT : (r < 56) ? OP_POP :
                      (r < 76) ? OP_REMOVE : (r < 97) ? OP_GET : 3'($urandom_range(5, 7));
      endcase
      if ($urandom_range(0, 99) < 15) pos = 5'($urandom);
      else if (op == OP_INSERT) pos = 5'($urandom_range(0, gen_len));
      else if (op == OP_REMOVE || op == OP_GET)
        pos = 5'($urandom_range(0, (gen_len > 0) ? gen_len - 1 : 0));
      else pos = 5'($urandom);
      add_req(op, pos, rand_word());
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (reqs_taken == total_reqs);
    wait (expected_rsps.size() == 0);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("positional_list_engine_core verification clean");
    end else begin
      $display("positional_list_engine_core verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("positional_list_engine_core verification failed");
    $finish;
  end

endmodule
